// File: design/mck_pkg.sv
// shared types, constants and the symbol table for the morse keyer
// used by every module of the keyer; depends on nothing
package mck_pkg;

  localparam int unsigned MaxElems = 6;

  localparam logic [2:0] DotUnits  = 3'd1;
  localparam logic [2:0] DashUnits = 3'd3;
  localparam logic [2:0] GapUnits  = 3'd1;
  localparam logic [2:0] WordUnits = 3'd7;

  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowZ  = 8'h7a;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharStop  = 8'h2e;

  typedef struct packed {
    logic       pause;
    logic [2:0] count;
    logic [5:0] pat;
  } mck_entry_t;

  // element count and dash pattern, first element in the highest used bit
  typedef struct packed {
    logic [2:0] count;
    logic [5:0] pat;
  } mck_sym_t;

  function automatic mck_sym_t mck_letter(input logic [4:0] idx);
    mck_sym_t s;
    case (idx)
      5'd0:  s = '{3'd2, 6'h01};
      5'd1:  s = '{3'd4, 6'h08};
      5'd2:  s = '{3'd4, 6'h0a};
      5'd3:  s = '{3'd3, 6'h04};
      5'd4:  s = '{3'd1, 6'h00};
      5'd5:  s = '{3'd4, 6'h02};
      5'd6:  s = '{3'd3, 6'h06};
      5'd7:  s = '{3'd4, 6'h00};
      5'd8:  s = '{3'd2, 6'h00};
      5'd9:  s = '{3'd4, 6'h07};
      5'd10: s = '{3'd3, 6'h05};
      5'd11: s = '{3'd4, 6'h04};
      5'd12: s = '{3'd2, 6'h03};
      5'd13: s = '{3'd2, 6'h02};
      5'd14: s = '{3'd3, 6'h07};
      5'd15: s = '{3'd4, 6'h06};
      5'd16: s = '{3'd4, 6'h0d};
      5'd17: s = '{3'd3, 6'h02};
      5'd18: s = '{3'd3, 6'h00};
      5'd19: s = '{3'd1, 6'h01};
      5'd20: s = '{3'd3, 6'h01};
      5'd21: s = '{3'd4, 6'h01};
      5'd22: s = '{3'd3, 6'h03};
      5'd23: s = '{3'd4, 6'h09};
      5'd24: s = '{3'd4, 6'h0b};
      5'd25: s = '{3'd4, 6'h0c};
      default: s = '{3'd1, 6'h00};
    endcase
    return s;
  endfunction

  function automatic mck_sym_t mck_digit(input logic [3:0] idx);
    mck_sym_t s;
    case (idx)
      4'd0: s = '{3'd5, 6'h1f};
      4'd1: s = '{3'd5, 6'h0f};
      4'd2: s = '{3'd5, 6'h07};
      4'd3: s = '{3'd5, 6'h03};
      4'd4: s = '{3'd5, 6'h01};
      4'd5: s = '{3'd5, 6'h00};
      4'd6: s = '{3'd5, 6'h10};
      4'd7: s = '{3'd5, 6'h18};
      4'd8: s = '{3'd5, 6'h1c};
      4'd9: s = '{3'd5, 6'h1e};
      default: s = '{3'd5, 6'h00};
    endcase
    return s;
  endfunction

  localparam mck_sym_t StopSym = '{3'd6, 6'h15};

endpackage

// File: design/mck_front.sv
// front end: classifies a character and looks up its element pattern
// depends on mck_pkg; feeds mck_queue
module mck_front import mck_pkg::*; (
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [7:0] character_i,
  output logic       push_o,
  output mck_entry_t entry_o
);

  logic     is_letter;
  logic     is_digit;
  logic     is_stop;
  logic [7:0] letter_off;
  logic [7:0] digit_off;
  mck_sym_t sym;

  assign is_letter  = (character_i >= CharLowA) && (character_i <= CharLowZ);
  assign is_digit   = (character_i >= CharZero) && (character_i <= CharNine);
  assign is_stop    = (character_i == CharStop);
  assign letter_off = character_i - CharLowA;
  assign digit_off  = character_i - CharZero;

  always_comb begin
    if (is_letter) begin
      sym = mck_letter(letter_off[4:0]);
    end else if (is_digit) begin
      sym = mck_digit(digit_off[3:0]);
    end else begin
      sym = StopSym;
    end
  end

  // left-align the pattern so the first element sits in the top bit
  assign entry_o.pause = !(is_letter || is_digit || is_stop);
  assign entry_o.count = sym.count;
  assign entry_o.pat   = sym.pat << (3'(MaxElems) - sym.count);
  assign push_o        = start_i && !busy_i;

endmodule

// File: design/mck_queue.sv
// two-word queue between the classifier and the segment sequencer
// depends on mck_pkg
module mck_queue import mck_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mck_entry_t entry_i,
  input  logic       pop_i,
  output logic       valid_o,
  output logic       full_o,
  output mck_entry_t entry_o
);

  mck_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("word pushed into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// File: design/mck_back.sv
// back end: steps through one word's elements, one keying segment a cycle
// depends on mck_pkg; reads words from mck_queue
module mck_back import mck_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  mck_entry_t entry_i,
  output logic       pop_o,
  output logic       seg_valid_o,
  output logic       key_on_o,
  output logic [2:0] duration_units_o,
  output logic       last_segment_o
);

  logic       active_q, active_d;
  logic       pause_q, pause_d;
  logic [2:0] count_q, count_d;
  logic [2:0] elem_q, elem_d;
  logic       gap_q, gap_d;
  logic [5:0] pat_q, pat_d;
  logic       finishing;
  logic       last_elem;

  logic       seg_valid_q;
  logic       key_on_q, key_on_d;
  logic [2:0] dur_q, dur_d;
  logic       last_q, last_d;

  assign last_elem = (elem_q == count_q - 3'd1);
  assign finishing = active_q && (pause_q || (gap_q && last_elem));
  assign pop_o     = valid_i && (!active_q || finishing);

  always_comb begin
    if (pause_q) begin
      key_on_d = 1'b0;
      dur_d    = WordUnits;
      last_d   = 1'b1;
    end else if (!gap_q) begin
      key_on_d = 1'b1;
      dur_d    = pat_q[5] ? DashUnits : DotUnits;
      last_d   = 1'b0;
    end else begin
      key_on_d = 1'b0;
      dur_d    = GapUnits;
      last_d   = last_elem;
    end
  end

  always_comb begin
    active_d = active_q;
    pause_d  = pause_q;
    count_d  = count_q;
    elem_d   = elem_q;
    gap_d    = gap_q;
    pat_d    = pat_q;
    if (pop_o) begin
      active_d = 1'b1;
      pause_d  = entry_i.pause;
      count_d  = entry_i.count;
      elem_d   = 3'd0;
      gap_d    = 1'b0;
      pat_d    = entry_i.pat;
    end else if (finishing) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (gap_q) begin
        gap_d  = 1'b0;
        elem_d = elem_q + 3'd1;
        pat_d  = pat_q << 1;
      end else begin
        gap_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      pause_q     <= 1'b0;
      count_q     <= 3'd0;
      elem_q      <= 3'd0;
      gap_q       <= 1'b0;
      seg_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      pause_q     <= pause_d;
      count_q     <= count_d;
      elem_q      <= elem_d;
      gap_q       <= gap_d;
      seg_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q    <= pat_d;
    key_on_q <= key_on_d;
    dur_q    <= dur_d;
    last_q   <= last_d;
  end

  assign seg_valid_o      = seg_valid_q;
  assign key_on_o         = key_on_q;
  assign duration_units_o = dur_q;
  assign last_segment_o   = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_valid_q && key_on_q) |-> !last_q)
    else $error("key-on segment marked last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_q |-> (dur_q == DotUnits || dur_q == DashUnits || dur_q == WordUnits))
    else $error("bad segment length");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !pause_q) |-> (elem_q < count_q))
    else $error("element index beyond count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finishing |=> (seg_valid_q && last_q))
    else $error("finished word without last segment");

endmodule

// File: design/morse_character_keyer.sv
// top level of the morse keyer: classifier, word queue and segment sequencer
// depends on mck_pkg, mck_front, mck_queue and mck_back
//
// usage
//   a character is taken on a rising edge with start high and busy low.
//   lowercase a to z, digits and the full stop become dot (1 unit) or dash
//   (3 units) key-on segments, each followed by a 1 unit key-off segment;
//   any other code gives one key-off segment of 7 units.
//   each segment is shown on key_on_o, duration_units_o and last_segment_o
//   for one cycle with seg_valid_o high; last_segment_o marks the final one.
//   when idle, the first segment reaches the outputs after the accepting edge
//   by way of the queue write, the sequencer load and the output register.
//   the sequencer emits one segment a cycle, so a character occupies it for
//   two segments per element (up to 12 for the full stop) or one for a pause, and
//   consecutive characters follow without a gap.
//   a two-word queue sits in front of the sequencer; busy is high only
//   while it is full, so up to two characters wait during a long run.
//   the receiver cannot stall: every segment is taken in its cycle.
//   reset empties the queue and stops any run in progress.
module morse_character_keyer import mck_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] character_i,
  output logic       seg_valid_o,
  output logic       key_on_o,
  output logic [2:0] duration_units_o,
  output logic       last_segment_o
);

  logic       push;
  logic       pop;
  logic       q_valid;
  logic       q_full;
  mck_entry_t front_entry;
  mck_entry_t back_entry;

  assign busy = q_full;

  mck_front u_front (
    .start_i     (start),
    .busy_i      (q_full),
    .character_i (character_i),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  mck_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .entry_o (back_entry)
  );

  mck_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_valid),
    .entry_i          (back_entry),
    .pop_o            (pop),
    .seg_valid_o      (seg_valid_o),
    .key_on_o         (key_on_o),
    .duration_units_o (duration_units_o),
    .last_segment_o   (last_segment_o)
  );

endmodule
